>>> rtl/gcs_pkg.sv
// Shared constants, types and the arctangent table function for the
// great-circle separation pipeline. No dependencies.
package gcs_pkg;

  // Angle resolution, in significant bits per turn.
  localparam int ANGLE_BITS   = 32;
  // Requested CORDIC iterations, capped by the arctangent table length.
  localparam int CORDIC_STEPS = 32;
  localparam int TABLE_LEN    = 48;
  localparam int STEPS        = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  // Word widths.
  localparam int IN_W   = 32;           // port angle width
  localparam int FRAC   = 30;           // vector component fraction bits
  localparam int PW     = 62;           // internal phase width, 2^62 per turn
  localparam int ZW     = 64;           // signed angle accumulator width
  localparam int XW     = 34;           // signed vector component width
  localparam int DW     = XW + 1;       // component difference width
  localparam int CW     = 64;           // squared chord width
  localparam int HW     = 61;           // saturated half-chord squared, up to 2^60
  localparam int RW     = 31;           // square root width, up to 2^30
  localparam int SQ_W   = 62;           // square-root working width
  localparam int SQRT_STEPS = 31;       // one result bit per stage

  localparam logic [63:0] LOW_CLEAR  = ~((64'd1 << (PW - ANGLE_BITS)) - 64'd1);
  localparam logic [63:0] INV_TWO_PI = 64'h28BE60DB9391054A;
  localparam logic signed [XW-1:0] GAIN = XW'(34'sh026DD3B6A);
  localparam logic [63:0] QUARTER    = 64'd1 << 60;

  // Handshake bits that ride along with each beat.
  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

  // Division of an elaboration constant by an odd literal.
  function automatic logic [63:0] div_odd(input logic [63:0] v, input int k);
    logic [63:0] r;
    case (k)
      0:  r = v;            1:  r = v / 64'd3;    2:  r = v / 64'd5;
      3:  r = v / 64'd7;    4:  r = v / 64'd9;    5:  r = v / 64'd11;
      6:  r = v / 64'd13;   7:  r = v / 64'd15;   8:  r = v / 64'd17;
      9:  r = v / 64'd19;   10: r = v / 64'd21;   11: r = v / 64'd23;
      12: r = v / 64'd25;   13: r = v / 64'd27;   14: r = v / 64'd29;
      15: r = v / 64'd31;   16: r = v / 64'd33;   17: r = v / 64'd35;
      18: r = v / 64'd37;   19: r = v / 64'd39;   20: r = v / 64'd41;
      21: r = v / 64'd43;   22: r = v / 64'd45;   23: r = v / 64'd47;
      24: r = v / 64'd49;   25: r = v / 64'd51;   26: r = v / 64'd53;
      27: r = v / 64'd55;   28: r = v / 64'd57;   29: r = v / 64'd59;
      30: r = v / 64'd61;
      default: r = '0;
    endcase
    return r;
  endfunction

  // atan(2^-i) at 2^62 units per turn, from a truncated Taylor series.
  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0]  rad;
    logic [63:0]  term;
    logic [127:0] prod;
    int           n;
    rad = '0;
    if (i == 0) begin
      return (64'd1 << 59) & LOW_CLEAR;
    end
    for (int k = 0; k < 31; k++) begin
      n = i * (2 * k + 1);
      if (n <= 62) begin
        term = div_odd(64'd1 << (62 - n), k);
        if (k[0]) begin
          rad = rad - term;
        end else begin
          rad = rad + term;
        end
      end
    end
    prod = {64'd0, rad} * {64'd0, INV_TWO_PI};
    return prod[127:64] & LOW_CLEAR;
  endfunction

endpackage

>>> rtl/gcs_sincos.sv
// Pipelined rotation-mode CORDIC giving sine and cosine of a phase.
// Depends on gcs_pkg for widths and the arctangent table.
module gcs_sincos (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic [gcs_pkg::PW-1:0]             phase_i,
  output logic                               valid_o,
  output logic signed [gcs_pkg::XW-1:0]      sin_o,
  output logic signed [gcs_pkg::XW-1:0]      cos_o
);

  localparam int S = gcs_pkg::STEPS;

  logic                              vld_q  [S+1];
  logic signed [gcs_pkg::XW-1:0]     x_q    [S+1];
  logic signed [gcs_pkg::XW-1:0]     y_q    [S+1];
  logic signed [gcs_pkg::ZW-1:0]     z_q    [S+1];
  logic                              flip_q [S+1];
  logic signed [gcs_pkg::ZW-1:0]     z0_d;
  logic                              flip0_d;
  logic                              vld_out_q;
  logic signed [gcs_pkg::XW-1:0]     sin_q, cos_q;
  logic [63:0]                       ph;

  // Fold the phase into the right half plane; the far half flips signs.
  always_comb begin
    ph = {2'b00, phase_i};
    if (ph >= gcs_pkg::QUARTER && ph < 3 * gcs_pkg::QUARTER) begin
      z0_d    = $signed(ph - 2 * gcs_pkg::QUARTER);
      flip0_d = 1'b1;
    end else if (ph >= 3 * gcs_pkg::QUARTER) begin
      z0_d    = $signed(ph - 4 * gcs_pkg::QUARTER);
      flip0_d = 1'b0;
    end else begin
      z0_d    = $signed(ph);
      flip0_d = 1'b0;
    end
  end

  // Entry register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= gcs_pkg::GAIN;
    y_q[0]    <= '0;
    z_q[0]    <= z0_d;
    flip_q[0] <= flip0_d;
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < S; i++) begin : g_step
    localparam logic signed [gcs_pkg::ZW-1:0] ATAN = $signed(gcs_pkg::atan_entry(i));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      flip_q[i+1] <= flip_q[i];
      if (!z_q[i][gcs_pkg::ZW-1]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - ATAN;
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + ATAN;
      end
    end
  end

  // Output register undoes the half-turn fold.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[S];
    end
  end

  always_ff @(posedge clk_i) begin
    sin_q <= flip_q[S] ? -y_q[S] : y_q[S];
    cos_q <= flip_q[S] ? -x_q[S] : x_q[S];
  end

  assign valid_o = vld_out_q;
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;

endmodule

>>> rtl/gcs_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on gcs_pkg for widths and the control struct.
module gcs_isqrt (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  gcs_pkg::ctl_t           ctl_i,
  input  logic [gcs_pkg::HW-1:0]  value_i,
  output gcs_pkg::ctl_t           ctl_o,
  output logic [gcs_pkg::RW-1:0]  root_o
);

  localparam int N = gcs_pkg::SQRT_STEPS;

  gcs_pkg::ctl_t                ctl_q [N+1];
  logic [gcs_pkg::SQ_W-1:0]     v_q   [N+1];
  logic [gcs_pkg::SQ_W-1:0]     r_q   [N+1];

  // Entry register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
    end else begin
      ctl_q[0] <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q[0] <= gcs_pkg::SQ_W'(value_i);
    r_q[0] <= '0;
  end

  // Trial subtraction of r + bit, bit moving down two places each stage.
  for (genvar j = 0; j < N; j++) begin : g_bit
    localparam logic [gcs_pkg::SQ_W-1:0] BIT = gcs_pkg::SQ_W'(1) << (60 - 2 * j);
    logic [gcs_pkg::SQ_W-1:0] trial;

    assign trial = r_q[j] + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[j+1] <= '0;
      end else begin
        ctl_q[j+1] <= ctl_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (v_q[j] >= trial) begin
        v_q[j+1] <= v_q[j] - trial;
        r_q[j+1] <= (r_q[j] >> 1) + BIT;
      end else begin
        v_q[j+1] <= v_q[j];
        r_q[j+1] <= r_q[j] >> 1;
      end
    end
  end

  assign ctl_o  = ctl_q[N];
  assign root_o = r_q[N][gcs_pkg::RW-1:0];

`ifndef SYNTHESIS
  // The input never exceeds 2^60, so the root never exceeds 2^30.
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.valid |-> r_q[N] <= (gcs_pkg::SQ_W'(1) << 30))
    else $error("square root out of range");
`endif

endmodule

>>> rtl/gcs_atan.sv
// Pipelined vectoring-mode CORDIC: angle of (x, y), clamped, doubled, scaled.
// Depends on gcs_pkg for widths, the table and the control struct.
module gcs_atan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gcs_pkg::ctl_t              ctl_i,
  input  logic [gcs_pkg::RW-1:0]     x_i,
  input  logic [gcs_pkg::RW-1:0]     y_i,
  output gcs_pkg::ctl_t              ctl_o,
  output logic [gcs_pkg::IN_W-1:0]   angle_o
);

  localparam int S = gcs_pkg::STEPS;

  gcs_pkg::ctl_t                   ctl_q [S+1];
  logic signed [gcs_pkg::XW-1:0]   x_q   [S+1];
  logic signed [gcs_pkg::XW-1:0]   y_q   [S+1];
  logic signed [gcs_pkg::ZW-1:0]   z_q   [S+1];
  gcs_pkg::ctl_t                   ctl_out_q;
  logic [gcs_pkg::IN_W-1:0]        angle_q;
  logic signed [gcs_pkg::ZW-1:0]   zc;

  // Entry register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
    end else begin
      ctl_q[0] <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0] <= $signed(gcs_pkg::XW'(x_i));
    y_q[0] <= $signed(gcs_pkg::XW'(y_i));
    z_q[0] <= '0;
  end

  // One micro-rotation toward the x axis per stage.
  for (genvar i = 0; i < S; i++) begin : g_step
    localparam logic signed [gcs_pkg::ZW-1:0] ATAN = $signed(gcs_pkg::atan_entry(i));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[i+1] <= '0;
      end else begin
        ctl_q[i+1] <= ctl_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (!y_q[i][gcs_pkg::XW-1]) begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + ATAN;
      end else begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - ATAN;
      end
    end
  end

  // Clamp to a quarter turn, then double into 2^32 units per turn.
  always_comb begin
    if (z_q[S] < 0) begin
      zc = '0;
    end else if (z_q[S] > $signed(gcs_pkg::QUARTER)) begin
      zc = $signed(gcs_pkg::QUARTER);
    end else begin
      zc = z_q[S];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_out_q <= '0;
    end else begin
      ctl_out_q <= ctl_q[S];
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= ctl_q[S].zero ? '0 : zc[29 +: gcs_pkg::IN_W];
  end

  assign ctl_o   = ctl_out_q;
  assign angle_o = angle_q;

`ifndef SYNTHESIS
  // A coincident pair always leaves the pipeline as zero.
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.valid && ctl_o.zero) |-> angle_o == '0)
    else $error("zero chord gave nonzero angle");
`endif

endmodule

>>> rtl/great_circle_separation.sv
// Top level: great-circle angle between two sky positions, fully pipelined.
// Depends on gcs_pkg, gcs_sincos, gcs_isqrt and gcs_atan.
//
//  channel   ports                                              direction
//  command   start_i, busy_o, first_ra_i, first_dec_i,           in
//            second_ra_i, second_dec_i
//  result    done_o, separation_o                               out
//
// One beat enters per cycle; busy_o is always low.
// done_o rises once a beat has passed the sine/cosine CORDICs with their entry
// and output registers, the product, square and half-chord registers, the
// 32-register square root, and the arctangent CORDIC with its entry and output registers.
// Reset clears only the valid and zero control bits; data registers are not reset.
// The receiver cannot stall, so nothing ever waits inside the pipeline.
module great_circle_separation (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [gcs_pkg::IN_W-1:0]         first_ra_i,
  input  logic signed [gcs_pkg::IN_W-1:0]  first_dec_i,
  input  logic [gcs_pkg::IN_W-1:0]         second_ra_i,
  input  logic signed [gcs_pkg::IN_W-1:0]  second_dec_i,
  output logic                             done_o,
  output logic [gcs_pkg::IN_W-1:0]         separation_o
);

  localparam int XW = gcs_pkg::XW;
  localparam logic [gcs_pkg::PW-1:0] PMASK = gcs_pkg::LOW_CLEAR[gcs_pkg::PW-1:0];

  logic                  take;
  logic [gcs_pkg::PW-1:0] ph_ra1, ph_dc1, ph_ra2, ph_dc2;
  logic                  v_ra1, v_dc1, v_ra2, v_dc2;
  logic signed [XW-1:0]  s_ra1, c_ra1, s_dc1, c_dc1, s_ra2, c_ra2, s_dc2, c_dc2;

  logic                  vb_q;
  logic signed [XW-1:0]  p0_q, p1_q, p2_q, q0_q, q1_q, q2_q;
  logic signed [2*XW-1:0] m_p0, m_p1, m_q0, m_q1;

  logic                  vc_q;
  logic [gcs_pkg::CW-1:0] sq0_q, sq1_q, sq2_q;
  logic [gcs_pkg::CW-1:0] sq0_d, sq1_d, sq2_d;

  gcs_pkg::ctl_t          ctl_d_q;
  logic [gcs_pkg::HW-1:0] h2_q, comp_q;
  logic [gcs_pkg::CW-1:0] chord2;
  logic [gcs_pkg::CW-3:0] h2_full;
  logic [gcs_pkg::HW-1:0] h2_sat;

  gcs_pkg::ctl_t          ctl_s, ctl_s_unused, ctl_out;
  logic [gcs_pkg::RW-1:0] root_y, root_x;

  assign busy_o = 1'b0;
  assign take   = start_i && !busy_o;

  // Input angles become phases at 2^62 per turn, trimmed to ANGLE_BITS.
  assign ph_ra1 = {first_ra_i,   30'd0} & PMASK;
  assign ph_dc1 = {first_dec_i,  30'd0} & PMASK;
  assign ph_ra2 = {second_ra_i,  30'd0} & PMASK;
  assign ph_dc2 = {second_dec_i, 30'd0} & PMASK;

  gcs_sincos u_ra1 (.clk_i, .rst_ni, .valid_i(take), .phase_i(ph_ra1),
                    .valid_o(v_ra1), .sin_o(s_ra1), .cos_o(c_ra1));
  gcs_sincos u_dc1 (.clk_i, .rst_ni, .valid_i(take), .phase_i(ph_dc1),
                    .valid_o(v_dc1), .sin_o(s_dc1), .cos_o(c_dc1));
  gcs_sincos u_ra2 (.clk_i, .rst_ni, .valid_i(take), .phase_i(ph_ra2),
                    .valid_o(v_ra2), .sin_o(s_ra2), .cos_o(c_ra2));
  gcs_sincos u_dc2 (.clk_i, .rst_ni, .valid_i(take), .phase_i(ph_dc2),
                    .valid_o(v_dc2), .sin_o(s_dc2), .cos_o(c_dc2));

  // Unit vectors: x = sin(ra)cos(dec), y = cos(ra)cos(dec), z = sin(dec).
  assign m_p0 = s_ra1 * c_dc1;
  assign m_p1 = c_ra1 * c_dc1;
  assign m_q0 = s_ra2 * c_dc2;
  assign m_q1 = c_ra2 * c_dc2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= v_ra1 & v_dc1 & v_ra2 & v_dc2;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q <= XW'(m_p0 >>> gcs_pkg::FRAC);
    p1_q <= XW'(m_p1 >>> gcs_pkg::FRAC);
    p2_q <= s_dc1;
    q0_q <= XW'(m_q0 >>> gcs_pkg::FRAC);
    q1_q <= XW'(m_q1 >>> gcs_pkg::FRAC);
    q2_q <= s_dc2;
  end

  // Squared component differences.
  function automatic logic [gcs_pkg::CW-1:0] sq_diff(input logic signed [XW-1:0] a,
                                                     input logic signed [XW-1:0] b);
    logic signed [gcs_pkg::DW-1:0] d;
    logic [gcs_pkg::DW-1:0]        u;
    logic [2*gcs_pkg::DW-1:0]      sq;
    d  = gcs_pkg::DW'(a) - gcs_pkg::DW'(b);
    u  = d[gcs_pkg::DW-1] ? gcs_pkg::DW'(-d) : gcs_pkg::DW'(d);
    sq = u * u;
    return sq[gcs_pkg::CW-1:0];
  endfunction

  assign sq0_d = sq_diff(p0_q, q0_q);
  assign sq1_d = sq_diff(p1_q, q1_q);
  assign sq2_d = sq_diff(p2_q, q2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq0_q <= sq0_d;
    sq1_q <= sq1_d;
    sq2_q <= sq2_d;
  end

  // Quarter of the squared chord, saturated at one, and its complement.
  assign chord2  = sq0_q + sq1_q + sq2_q;
  assign h2_full = chord2[gcs_pkg::CW-1:2];
  assign h2_sat  = (h2_full > (gcs_pkg::CW-2)'(gcs_pkg::QUARTER)) ?
                   gcs_pkg::HW'(gcs_pkg::QUARTER) : h2_full[gcs_pkg::HW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_d_q <= '0;
    end else begin
      ctl_d_q.valid <= vc_q;
      ctl_d_q.zero  <= (h2_full == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    h2_q   <= h2_sat;
    comp_q <= gcs_pkg::HW'(gcs_pkg::QUARTER) - h2_sat;
  end

  // y = sqrt(h^2), x = sqrt(1 - h^2).
  gcs_isqrt u_sqrt_y (.clk_i, .rst_ni, .ctl_i(ctl_d_q), .value_i(h2_q),
                      .ctl_o(ctl_s), .root_o(root_y));
  gcs_isqrt u_sqrt_x (.clk_i, .rst_ni, .ctl_i(ctl_d_q), .value_i(comp_q),
                      .ctl_o(ctl_s_unused), .root_o(root_x));

  // Separation is twice atan2(y, x).
  gcs_atan u_atan (.clk_i, .rst_ni, .ctl_i(ctl_s), .x_i(root_x), .y_i(root_y),
                   .ctl_o(ctl_out), .angle_o(separation_o));

  assign done_o = ctl_out.valid;

`ifndef SYNTHESIS
  // A separation never exceeds a half turn.
  a_half_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> separation_o <= 32'h8000_0000)
    else $error("separation above half turn");

  // The two square roots see the same beat, and their inputs always add up to one.
  a_sum_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_d_q.valid |-> (gcs_pkg::CW'(h2_q) + gcs_pkg::CW'(comp_q) == gcs_pkg::QUARTER)
                      && (ctl_s == ctl_s_unused))
    else $error("half-chord terms inconsistent");
`endif

endmodule
